FILE: rtl/pxansi_pkg.sv
// ----------------------------------------------------------------------------
// pxansi_pkg
// Shared types, byte codes and helpers for the pixel to ANSI color encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pxansi_pkg;

  // Default limits for the frame geometry.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Configuration register port.
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0]  RST_FRAME_WIDTH  = 11'd80;
  localparam logic [CFG_DATA_W-1:0]  RST_FRAME_HEIGHT = 11'd24;

  // Command queue depth between the classifier and the byte sequencer.
  localparam int QDEPTH = 2;

  // Byte codes of the terminal stream.
  localparam logic [7:0] CH_ESC     = 8'h1b;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_FOUR    = 8'h34;
  localparam logic [7:0] CH_EIGHT   = 8'h38;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_M       = 8'h6d;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Decimal digits of one color component.
  typedef struct packed {
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] u;
  } digits_t;

  // Everything the sequencer needs to produce the bytes of one pixel.
  typedef struct packed {
    logic       home;
    logic       colour_change;
    digits_t    red_d;
    digits_t    green_d;
    digits_t    blue_d;
    logic [7:0] glyph_byte;
    logic       newline;
    logic       frame_end;
  } cmd_t;

  // Byte positions of the sequencer.
  typedef enum logic [4:0] {
    ST_HOME0, ST_HOME1, ST_HOME2,
    ST_COL0, ST_COL1, ST_COL2, ST_COL3, ST_COL4, ST_COL5, ST_COL6,
    ST_R_H, ST_R_T, ST_R_U, ST_R_SEMI,
    ST_G_H, ST_G_T, ST_G_U, ST_G_SEMI,
    ST_B_H, ST_B_T, ST_B_U, ST_B_M,
    ST_GLYPH, ST_NL,
    ST_END0, ST_END1, ST_END2, ST_END3
  } step_t;

  // Binary to three BCD digits by shift and add-three.
  function automatic digits_t to_digits(input logic [7:0] v);
    logic [19:0] s;
    digits_t     d;
    s = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (s[11:8] >= 4'd5) begin
        s[11:8] = s[11:8] + 4'd3;
      end
      if (s[15:12] >= 4'd5) begin
        s[15:12] = s[15:12] + 4'd3;
      end
      s = s << 1;
    end
    d.h = s[19:16];
    d.t = s[15:12];
    d.u = s[11:8];
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pxansi_pixel_if.sv
// ----------------------------------------------------------------------------
// pxansi_pixel_if
// Pixel channel: color components and glyph with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pxansi_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] glyph;

  modport source (output valid, output red, output green, output blue, output glyph,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input glyph,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/pxansi_byte_if.sv
// ----------------------------------------------------------------------------
// pxansi_byte_if
// Byte channel: terminal stream byte with pixel and frame end marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface pxansi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       pixel_done;
  logic       frame_done;

  modport source (output valid, output out_byte, output pixel_done, output frame_done,
                  input ready);
  modport sink (input valid, input out_byte, input pixel_done, input frame_done,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/pxansi_front.sv
// ----------------------------------------------------------------------------
// pxansi_front
// Accepts pixels, tracks raster position and color, and builds byte commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pxansi_front
  import pxansi_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  pxansi_pixel_if.sink               pixel_in,
  input  wire logic [CFG_DATA_W-1:0] frame_width,
  input  wire logic [CFG_DATA_W-1:0] frame_height,
  input  wire logic                  q_full,
  output      logic                  q_push,
  output      cmd_t                  q_data
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WWX = $clog2(MAX_WIDTH + 1);
  localparam int HWX = $clog2(MAX_HEIGHT + 1);
  localparam int DWA = (WWX > CFG_DATA_W) ? WWX : CFG_DATA_W;
  localparam int DWB = (HWX > CFG_DATA_W) ? HWX : CFG_DATA_W;
  localparam int DW  = ((DWA > DWB) ? DWA : DWB) + 1;

  logic [CW-1:0] column;
  logic [RW-1:0] row;
  logic [23:0]   previous_colour;
  logic          frame_start;

  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;
  logic [DW-1:0] col_plus;
  logic [DW-1:0] row_plus;
  logic          last_col;
  logic          last_row;
  logic [23:0]   colour;
  logic [23:0]   base_colour;

  assign pixel_in.ready = !q_full;
  assign q_push         = pixel_in.valid && !q_full;

  // Zero counts as one and anything above the maximum counts as the maximum.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = DW'(1);
    end else if (DW'(frame_width) > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = DW'(1);
    end else if (DW'(frame_height) > DW'(MAX_HEIGHT)) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = DW'(frame_height);
    end
  end

  assign col_plus    = DW'(column) + DW'(1);
  assign row_plus    = DW'(row) + DW'(1);
  assign last_col    = col_plus >= w_eff;
  assign last_row    = row_plus >= h_eff;
  assign colour      = {pixel_in.red, pixel_in.green, pixel_in.blue};
  // Every frame starts from black.
  assign base_colour = frame_start ? 24'd0 : previous_colour;

  always_comb begin
    q_data.home          = frame_start;
    q_data.colour_change = colour != base_colour;
    q_data.red_d         = to_digits(pixel_in.red);
    q_data.green_d       = to_digits(pixel_in.green);
    q_data.blue_d        = to_digits(pixel_in.blue);
    q_data.glyph_byte    = (pixel_in.glyph == 8'd0) ? CH_SPACE : pixel_in.glyph;
    q_data.newline       = last_col;
    q_data.frame_end     = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      row             <= '0;
      previous_colour <= '0;
      frame_start     <= 1'b1;
    end else if (q_push) begin
      previous_colour <= colour;
      if (last_col) begin
        column <= '0;
        if (last_row) begin
          row         <= '0;
          frame_start <= 1'b1;
        end else begin
          row <= row_plus[RW-1:0];
        end
      end else begin
        column <= col_plus[CW-1:0];
      end
      if (!last_col || !last_row) begin
        frame_start <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pxansi_queue.sv
// ----------------------------------------------------------------------------
// pxansi_queue
// Short command queue between the pixel classifier and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pxansi_queue
  import pxansi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  input  wire logic pop,
  output      logic full,
  output      logic not_empty,
  output      cmd_t head
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;

  assign full      = count == QCW'(QDEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QAW'(QDEPTH - 1)) ? '0 : wptr + QAW'(1);
      end
      if (pop) begin
        rptr <= (rptr == QAW'(QDEPTH - 1)) ? '0 : rptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pxansi_back.sv
// ----------------------------------------------------------------------------
// pxansi_back
// Byte sequencer: walks each command through its escape, glyph and end bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module pxansi_back
  import pxansi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_valid,
  input  cmd_t          q_head,
  output      logic     q_pop,
  pxansi_byte_if.source byte_out
);

  cmd_t       cur;
  logic       busy;
  step_t      step;
  step_t      step_next;
  step_t      start_step;
  logic       last;
  logic [7:0] byte_val;

  logic       ov;
  logic [7:0] ob;
  logic       opd;
  logic       ofd;

  logic       out_free;
  logic       emit;

  function automatic step_t comp_entry(input digits_t d, input step_t sh, input step_t st,
                                       input step_t su, input step_t sterm);
    step_t s;
    if (d.h != 4'd0) begin
      s = sh;
    end else if (d.t != 4'd0) begin
      s = st;
    end else if (d.u != 4'd0) begin
      s = su;
    end else begin
      s = sterm;
    end
    return s;
  endfunction

  assign out_free = !ov || byte_out.ready;
  assign emit     = busy && out_free;
  assign q_pop    = q_valid && (!busy || (emit && last));

  always_comb begin
    if (q_head.home) begin
      start_step = ST_HOME0;
    end else if (q_head.colour_change) begin
      start_step = ST_COL0;
    end else begin
      start_step = ST_GLYPH;
    end
  end

  // Next state.
  always_comb begin
    step_next = step;
    last      = 1'b0;
    case (step)
      ST_HOME0:  step_next = ST_HOME1;
      ST_HOME1:  step_next = ST_HOME2;
      ST_HOME2:  step_next = cur.colour_change ? ST_COL0 : ST_GLYPH;
      ST_COL0:   step_next = ST_COL1;
      ST_COL1:   step_next = ST_COL2;
      ST_COL2:   step_next = ST_COL3;
      ST_COL3:   step_next = ST_COL4;
      ST_COL4:   step_next = ST_COL5;
      ST_COL5:   step_next = ST_COL6;
      ST_COL6:   step_next = comp_entry(cur.red_d, ST_R_H, ST_R_T, ST_R_U, ST_R_SEMI);
      ST_R_H:    step_next = ST_R_T;
      ST_R_T:    step_next = ST_R_U;
      ST_R_U:    step_next = ST_R_SEMI;
      ST_R_SEMI: step_next = comp_entry(cur.green_d, ST_G_H, ST_G_T, ST_G_U, ST_G_SEMI);
      ST_G_H:    step_next = ST_G_T;
      ST_G_T:    step_next = ST_G_U;
      ST_G_U:    step_next = ST_G_SEMI;
      ST_G_SEMI: step_next = comp_entry(cur.blue_d, ST_B_H, ST_B_T, ST_B_U, ST_B_M);
      ST_B_H:    step_next = ST_B_T;
      ST_B_T:    step_next = ST_B_U;
      ST_B_U:    step_next = ST_B_M;
      ST_B_M:    step_next = ST_GLYPH;
      ST_GLYPH: begin
        if (cur.newline) begin
          step_next = ST_NL;
        end else begin
          last = 1'b1;
        end
      end
      ST_NL: begin
        if (cur.frame_end) begin
          step_next = ST_END0;
        end else begin
          last = 1'b1;
        end
      end
      ST_END0:   step_next = ST_END1;
      ST_END1:   step_next = ST_END2;
      ST_END2:   step_next = ST_END3;
      ST_END3:   last = 1'b1;
      default:   last = 1'b1;
    endcase
  end

  // Outputs.
  always_comb begin
    case (step)
      ST_HOME0, ST_COL0, ST_END0: byte_val = CH_ESC;
      ST_HOME1, ST_COL1, ST_END1: byte_val = CH_LBRACK;
      ST_HOME2:                   byte_val = CH_H;
      ST_COL2:                    byte_val = CH_FOUR;
      ST_COL3:                    byte_val = CH_EIGHT;
      ST_COL5:                    byte_val = CH_TWO;
      ST_COL4, ST_COL6, ST_R_SEMI, ST_G_SEMI: byte_val = CH_SEMI;
      ST_R_H:                     byte_val = CH_ZERO + {4'd0, cur.red_d.h};
      ST_R_T:                     byte_val = CH_ZERO + {4'd0, cur.red_d.t};
      ST_R_U:                     byte_val = CH_ZERO + {4'd0, cur.red_d.u};
      ST_G_H:                     byte_val = CH_ZERO + {4'd0, cur.green_d.h};
      ST_G_T:                     byte_val = CH_ZERO + {4'd0, cur.green_d.t};
      ST_G_U:                     byte_val = CH_ZERO + {4'd0, cur.green_d.u};
      ST_B_H:                     byte_val = CH_ZERO + {4'd0, cur.blue_d.h};
      ST_B_T:                     byte_val = CH_ZERO + {4'd0, cur.blue_d.t};
      ST_B_U:                     byte_val = CH_ZERO + {4'd0, cur.blue_d.u};
      ST_B_M, ST_END3:            byte_val = CH_M;
      ST_GLYPH:                   byte_val = cur.glyph_byte;
      ST_NL:                      byte_val = CH_NEWLINE;
      ST_END2:                    byte_val = CH_ZERO;
      default:                    byte_val = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ov   <= 1'b0;
      step <= ST_GLYPH;
    end else begin
      if (out_free) begin
        ov <= emit;
      end
      // A new command taken on the last byte of the current one starts at once.
      if (q_pop) begin
        step <= start_step;
        busy <= 1'b1;
      end else if (emit) begin
        step <= step_next;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob  <= byte_val;
      opd <= last;
      ofd <= last && (step == ST_END3);
    end
    if (q_pop) begin
      cur <= q_head;
    end
  end

  assign byte_out.valid      = ov;
  assign byte_out.out_byte   = ob;
  assign byte_out.pixel_done = opd;
  assign byte_out.frame_done = ofd;

  a_frame_done_ends_pixel: assert property (@(posedge clk) disable iff (rst)
    ov && ofd |-> opd)
    else $error("frame_done without pixel_done");

  a_end_only_at_frame_end: assert property (@(posedge clk) disable iff (rst)
    busy && (step == ST_END0 || step == ST_END1 || step == ST_END2 || step == ST_END3)
    |-> cur.frame_end)
    else $error("reset sequence outside frame end");

  a_escape_only_on_change: assert property (@(posedge clk) disable iff (rst)
    busy && (step == ST_COL0 || step == ST_R_SEMI || step == ST_B_M)
    |-> cur.colour_change)
    else $error("color escape without color change");

  a_hundreds_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy && step == ST_R_H |-> cur.red_d.h != 4'd0)
    else $error("leading zero digit emitted");

endmodule

`default_nettype wire

FILE: rtl/pixel_to_ansi_color_encoder.sv
// ----------------------------------------------------------------------------
// pixel_to_ansi_color_encoder
// Turns raster pixels into a terminal byte stream with 24-bit background color.
// ----------------------------------------------------------------------------
//
//   Channel    Dir  Handshake        Payload
//   pixel_in   in   valid / ready    red, green, blue, glyph (8 bits each)
//   byte_out   out  valid / ready    out_byte (8), pixel_done, frame_done
//   cfg        in   cfg_we           cfg_index (1), cfg_data (11)
//
// A pixel produces between 1 and 28 bytes and the byte sequencer emits one
// byte per cycle while byte_out is ready. It takes the next queued command on
// the last byte of the current one, so queued pixels leave no idle slot.
// The single byte output register of the sequencer sets this throughput.
// Reset is synchronous and clears position, color tracking, the queue and the
// output register; there is no clearing pass.
// The classifier and sequencer are split by a two-entry command queue, so a
// stalled byte sink backs up into the queue before pixel_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_ansi_color_encoder
  import pxansi_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  pxansi_pixel_if.sink                pixel_in,
  pxansi_byte_if.source               byte_out,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // Geometry registers. The user must change them only while the block is idle;
  // the block does not enforce it, and the classifier reads them directly.
  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t q_in;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each pixel transaction into one command: which
  // escapes it needs, the decimal digits of its color, and its row and frame
  // endings.
  pxansi_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel_in     (pixel_in),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  pxansi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // The back end steps through each command's bytes, one byte transaction per
  // cycle while the sink is ready, and marks the last byte of pixel and frame.
  pxansi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .byte_out (byte_out)
  );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel to ANSI color encoder. A table of directed
// pixels and register writes runs first, then several random phases, each
// with its own frame geometry. Every accepted pixel is run through a bench-side
// encoder, and the byte stream of the block is compared against it byte by byte.
// ----------------------------------------------------------------------------

module tb_top;
  import pxansi_pkg::*;

  // Cycles to wait after the last expected byte before the bench treats the
  // block as idle. Every pixel causes at least one byte, so this is only margin.
  localparam int SETTLE        = 4;
  // Cycles with no transaction on any port before the run is declared hung.
  // The longest legal quiet stretch is a sender gap plus a receiver stall
  // plus the settle time.
  localparam int HANG_LIMIT    = 2000;
  localparam int PHASES        = 7;
  localparam int PIXELS_PER_PHASE = 36;
  localparam int TAIL_CYCLES   = 20;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

  // One line of the directed script: either a pixel or a register write.
  typedef struct packed {
    row_kind_t              kind;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [7:0]             glyph;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    logic                   frame_end;
  } script_row_t;

  // One byte of the terminal stream with its end marks.
  typedef struct packed {
    logic [7:0] code;
    logic       pixel_end;
    logic       frame_end;
  } term_byte_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pxansi_pixel_if px ();
  pxansi_byte_if  bo ();

  pixel_to_ansi_color_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (px),
    .byte_out  (bo),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench-side encoder. It keeps its own copy of the frame position, the last
  // color and the geometry registers, and turns one pixel into the bytes the
  // block should emit for it.
  // --------------------------------------------------------------------------
  logic [9:0]            col_pos;
  logic [9:0]            row_pos;
  logic [23:0]           last_rgb;
  logic                  at_frame_top;
  logic [CFG_DATA_W-1:0] geo_width;
  logic [CFG_DATA_W-1:0] geo_height;

  term_byte_t pixel_bytes[$];     // bytes of the pixel just encoded
  term_byte_t expected_stream[$]; // bytes still owed by the block

  function automatic void emit(input logic [7:0] code);
    pixel_bytes.push_back('{code: code, pixel_end: 1'b0, frame_end: 1'b0});
  endfunction

  // Decimal digits without leading zeros. A zero component gives no digit at
  // all, only the terminator, so black reads as ESC[48;2;;;m.
  function automatic void emit_decimal(input logic [7:0] v, input logic [7:0] term);
    if (v >= 8'd100) emit(CH_ZERO + v / 8'd100);
    if (v >= 8'd10)  emit(CH_ZERO + (v / 8'd10) % 8'd10);
    if (v != 8'd0)   emit(CH_ZERO + v % 8'd10);
    emit(term);
  endfunction

  function automatic void encode_pixel(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic [7:0] gl);
    logic [23:0] rgb;
    int          w;
    int          h;
    logic        frame_over;
    pixel_bytes.delete();
    rgb = {r, g, b};
    // Zero geometry counts as one, anything past the maximum as the maximum.
    w = (geo_width == 0) ? 1 : ((geo_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : geo_width);
    h = (geo_height == 0) ? 1 :
        ((geo_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : geo_height);
    frame_over = 1'b0;

    // The first pixel of a frame homes the cursor, and color tracking starts
    // from black, so a black first pixel needs no color escape.
    if (at_frame_top) begin
      emit(CH_ESC);
      emit(CH_LBRACK);
      emit(CH_H);
      last_rgb = '0;
      at_frame_top = 1'b0;
    end
    if (rgb != last_rgb) begin
      emit(CH_ESC);
      emit(CH_LBRACK);
      emit(CH_FOUR);
      emit(CH_EIGHT);
      emit(CH_SEMI);
      emit(CH_TWO);
      emit(CH_SEMI);
      emit_decimal(r, CH_SEMI);
      emit_decimal(g, CH_SEMI);
      emit_decimal(b, CH_M);
    end
    last_rgb = rgb;
    emit((gl == 8'd0) ? CH_SPACE : gl);

    // A geometry write can leave the position past the new last column or
    // row; the comparison with >= closes the row or frame right here.
    if (int'(col_pos) + 1 >= w) begin
      emit(CH_NEWLINE);
      col_pos = '0;
      if (int'(row_pos) + 1 >= h) begin
        emit(CH_ESC);
        emit(CH_LBRACK);
        emit(CH_ZERO);
        emit(CH_M);
        row_pos = '0;
        last_rgb = '0;
        at_frame_top = 1'b1;
        frame_over = 1'b1;
      end else begin
        row_pos = row_pos + 10'd1;
      end
    end else begin
      col_pos = col_pos + 10'd1;
    end
    pixel_bytes[pixel_bytes.size() - 1].pixel_end = 1'b1;
    pixel_bytes[pixel_bytes.size() - 1].frame_end = frame_over;
  endfunction

  // --------------------------------------------------------------------------
  // Checking. One process samples all ports at the rising edge: register
  // writes update the encoder's geometry, an accepted pixel appends its bytes
  // to the expected stream, and an accepted byte is compared with the oldest
  // entry. For the rows of the directed script whose bytes are typed in, those
  // typed bytes are owed instead, while the encoder still advances its state.
  // --------------------------------------------------------------------------
  string typed_bytes;  // typed expectation of the pixel on the bus, or empty
  logic  typed_fend;
  int    mismatches;
  int    bytes_seen;

  function automatic void flag(input string msg);
    if (mismatches < 10) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    term_byte_t got;
    term_byte_t want;
    if (rst) begin
      col_pos      = '0;
      row_pos      = '0;
      last_rgb     = '0;
      at_frame_top = 1'b1;
      geo_width    = RST_FRAME_WIDTH;
      geo_height   = RST_FRAME_HEIGHT;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FRAME_WIDTH) geo_width = cfg_data;
        else geo_height = cfg_data;
      end
      if (px.valid && px.ready) begin
        encode_pixel(px.red, px.green, px.blue, px.glyph);
        if (typed_bytes.len() != 0) begin
          for (int i = 0; i < typed_bytes.len(); i++) begin
            expected_stream.push_back('{code: typed_bytes[i],
                                        pixel_end: (i == typed_bytes.len() - 1),
                                        frame_end: (i == typed_bytes.len() - 1) && typed_fend});
          end
        end else begin
          foreach (pixel_bytes[i]) expected_stream.push_back(pixel_bytes[i]);
        end
      end
      if (bo.valid && bo.ready) begin
        got = '{code: bo.out_byte, pixel_end: bo.pixel_done, frame_end: bo.frame_done};
        if (expected_stream.size() == 0) begin
          flag($sformatf("byte %0d: unexpected byte %h pixel_done %b frame_done %b",
                         bytes_seen, got.code, got.pixel_end, got.frame_end));
        end else begin
          want = expected_stream.pop_front();
          if (got.code !== want.code || got.pixel_end !== want.pixel_end ||
              got.frame_end !== want.frame_end) begin
            flag($sformatf({"byte %0d: expected %h pixel_done %b frame_done %b, ",
                            "got %h pixel_done %b frame_done %b"},
                           bytes_seen, want.code, want.pixel_end, want.frame_end,
                           got.code, got.pixel_end, got.frame_end));
          end
        end
        bytes_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if no transaction and no register write happens for
  // too long.
  // --------------------------------------------------------------------------
  int hang_count;

  always @(posedge clk) begin
    if (rst || cfg_we || (px.valid && px.ready) || (bo.valid && bo.ready)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Byte sink. Ready drops in random bursts at random, except while the bench
  // runs a calm stretch.
  // --------------------------------------------------------------------------
  logic calm;
  int   stall_left;

  always @(negedge clk) begin
    logic take;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      take = 1'b0;
    end else begin
      take = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
    end
    bo.ready <= take;
  end

  // --------------------------------------------------------------------------
  // Pixel source. All tasks are entered and left at a falling edge, so inputs
  // only ever change there.
  // --------------------------------------------------------------------------

  // Presents one pixel and holds it until a transaction takes it. Valid is
  // left high so that a following pixel can go out back to back.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] gl);
    px.valid <= 1'b1;
    px.red   <= r;
    px.green <= g;
    px.blue  <= b;
    px.glyph <= gl;
    do @(posedge clk); while (!px.ready);
    @(negedge clk);
  endtask

  task automatic pause(input int cycles);
    px.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Holds the source until every owed byte has come out, then a little more.
  task automatic wait_drained();
    px.valid <= 1'b0;
    while (expected_stream.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Geometry registers are only written with the block idle.
  task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random sender gap, now and then.
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) pause($urandom_range(1, 9));
  endtask

  // A color component, leaning on the places where the digit count changes.
  function automatic logic [7:0] pick_component();
    logic [7:0] edges[8];
    edges = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd199, 8'd200, 8'd255};
    if ($urandom_range(0, 2) == 0) return edges[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Directed script.
  // --------------------------------------------------------------------------
  script_row_t script[$];
  string       script_want[$];

  task automatic add_px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                        input logic [7:0] gl, input string want, input logic fend);
    script.push_back('{kind: ROW_PIXEL, red: r, green: g, blue: b, glyph: gl,
                       reg_index: '0, reg_value: '0, frame_end: fend});
    script_want.push_back(want);
  endtask

  task automatic add_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    script.push_back('{kind: ROW_REG, red: '0, green: '0, blue: '0, glyph: '0,
                       reg_index: idx, reg_value: v, frame_end: 1'b0});
    script_want.push_back("");
  endtask

  initial begin
    logic [23:0] last_sent;
    logic [23:0] rgb;
    logic [7:0]  gl;
    int          w;
    int          h;

    // Every input of the block is known from time zero.
    px.valid   = 1'b0;
    px.red     = '0;
    px.green   = '0;
    px.blue    = '0;
    px.glyph   = '0;
    bo.ready   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_FRAME_WIDTH;
    cfg_data   = '0;
    calm       = 1'b0;
    stall_left = 0;
    mismatches = 0;
    bytes_seen = 0;
    hang_count = 0;
    typed_bytes = "";
    typed_fend = 1'b0;
    last_sent  = '0;

    // Right after reset the geometry is 80 by 24 and tracking starts black,
    // so the first few byte sequences can be written out by hand.
    add_px(8'd0, 8'd0, 8'd0, 8'd0, "\033[H ", 1'b0);
    add_px(8'd255, 8'd255, 8'd255, 8'h41, "\033[48;2;255;255;255mA", 1'b0);
    add_px(8'd255, 8'd255, 8'd255, 8'hff, "\377", 1'b0);
    add_px(8'd1, 8'd10, 8'd100, 8'h7f, "\033[48;2;1;10;100m\177", 1'b0);
    // Returning to black: zero components print no digits.
    add_px(8'd0, 8'd0, 8'd0, 8'h23, "\033[48;2;;;m#", 1'b0);
    add_px(8'h80, 8'h40, 8'h20, 8'h01, "", 1'b0);
    add_px(8'd9, 8'd99, 8'd200, 8'h55, "", 1'b0);
    // Narrowing the row while the column is already past its new end closes
    // the row after the next pixel; the same goes for the height.
    add_reg(CFG_FRAME_WIDTH, 11'd3);
    add_px(8'd9, 8'd99, 8'd0, 8'haa, "", 1'b0);
    add_reg(CFG_FRAME_HEIGHT, 11'd2);
    add_px(8'd10, 8'd199, 8'd0, 8'h00, "", 1'b0);
    add_px(8'd10, 8'd199, 8'd0, 8'h7e, "", 1'b0);
    add_px(8'd100, 8'd0, 8'd9, 8'h80, "", 1'b0);
    // First pixel of a new frame: cursor home, tracking back to black.
    add_px(8'd0, 8'd0, 8'd0, 8'h78, "", 1'b0);
    add_px(8'd255, 8'd0, 8'd0, 8'h00, "", 1'b0);
    // Zero geometry counts as a one by one frame: every pixel is a frame.
    add_reg(CFG_FRAME_WIDTH, 11'd0);
    add_reg(CFG_FRAME_HEIGHT, 11'd0);
    add_px(8'd0, 8'd255, 8'd0, 8'h7a, "", 1'b0);
    add_px(8'd0, 8'd0, 8'd0, 8'h00, "\033[H \n\033[0m", 1'b1);
    // The longest sequence a pixel can cause.
    add_px(8'd255, 8'd255, 8'd255, 8'h00, "\033[H\033[48;2;255;255;255m \n\033[0m", 1'b1);
    // Geometry past the maximum is clamped to it.
    add_reg(CFG_FRAME_WIDTH, 11'd2047);
    add_reg(CFG_FRAME_HEIGHT, 11'd2047);
    add_px(8'd199, 8'd200, 8'd255, 8'h40, "", 1'b0);
    add_px(8'd199, 8'd200, 8'd255, 8'h00, "", 1'b0);

    // Synchronous reset, released at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        set_register(script[i].reg_index, script[i].reg_value);
      end else begin
        typed_bytes = script_want[i];
        typed_fend  = script[i].frame_end;
        send_pixel(script[i].red, script[i].green, script[i].blue, script[i].glyph);
        maybe_gap();
      end
    end
    typed_bytes = "";

    // Random phases, each with its own geometry. Small frames keep the frame
    // ends frequent; one phase runs the widest row, and the next one shrinks
    // it again while the column is deep into the row.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          w = 1;
          h = 1;
        end
        1: begin
          w = 2047;
          h = 2047;
        end
        2: begin
          w = 3;
          h = 2047;
        end
        3: begin
          w = 4;
          h = 3;
        end
        4: begin
          w = 2;
          h = 1;
        end
        default: begin
          w = $urandom_range(1, 9);
          h = $urandom_range(1, 4);
        end
      endcase
      // The last phase runs without any idling; others are calm at random.
      // Deciding before the register writes lets any sink stall run out first.
      calm = (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
      set_register(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
      set_register(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));

      repeat (PIXELS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0, 1, 2: rgb = last_sent;   // same color: glyph only within a frame
          3:       rgb = '0;
          4:       rgb = {pick_component(), pick_component(), pick_component()};
          default: rgb = 24'($urandom());
        endcase
        gl = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        last_sent = rgb;
        send_pixel(rgb[23:16], rgb[15:8], rgb[7:0], gl);
        // Once in a while the source holds off until the output has caught up.
        if (!calm && $urandom_range(0, 39) == 0) wait_drained();
        else maybe_gap();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_stream.size() != 0) begin
      flag($sformatf("%0d expected bytes never arrived", expected_stream.size()));
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
